// ===== hw/rtl/mp2d_pkg.sv =====
package mp2d_pkg;

   localparam int SIZE_W       = 11;
   localparam int SIZE_CAP     = 1024;
   localparam int POOL_RAW_W   = 4;
   localparam int POOL_SIZE_W  = 5;
   localparam int FLOOR_W      = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = 2;

   localparam logic [SIZE_W-1:0]     FRAME_ROWS_RESET    = 11'd1;
   localparam logic [SIZE_W-1:0]     FRAME_COLS_RESET    = 11'd1;
   localparam logic [SIZE_W-1:0]     CHANNEL_COUNT_RESET = 11'd1;
   localparam logic [POOL_RAW_W-1:0] POOL_H_RESET        = 4'd2;
   localparam logic [POOL_RAW_W-1:0] POOL_W_RESET        = 4'd2;
   localparam logic [FLOOR_W-1:0]    FLOOR_VALUE_RESET   = 16'h9C00;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_ROWS    = 3'd0,
      CSR_FRAME_COLS    = 3'd1,
      CSR_CHANNEL_COUNT = 3'd2,
      CSR_POOL_H        = 3'd3,
      CSR_POOL_W        = 3'd4,
      CSR_FLOOR_VALUE   = 3'd5
   } csr_index_type;

   // sizes after clamping, as the front sees them
   typedef struct packed {
      logic [SIZE_W-1:0]      rows;
      logic [SIZE_W-1:0]      cols;
      logic [SIZE_W-1:0]      chans;
      logic [POOL_SIZE_W-1:0] ph;
      logic [POOL_SIZE_W-1:0] pw;
   } size_cfg_type;

   // where a sample sits in its window
   typedef struct packed {
      logic first_col;
      logic col_end;
      logic row_first;
      logic row_end;
      logic ch_done;
      logic blk_done;
   } win_flags_type;

endpackage

// ===== hw/rtl/mp2d_req_if.sv =====
interface mp2d_req_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/mp2d_rsp_if.sv =====
interface mp2d_rsp_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] pooled;
   logic                          channel_done;
   logic                          block_done;

   modport source (output valid, output pooled, output channel_done, output block_done,
                   input ready);
   modport sink   (input valid, input pooled, input channel_done, input block_done,
                   output ready);
endinterface

// ===== hw/rtl/mp2d_csr_if.sv =====
interface mp2d_csr_if ();
   logic                                  valid;
   logic                                  ready;
   logic [mp2d_pkg::CSR_INDEX_W-1:0]      index;
   logic [mp2d_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mp2d_front.sv =====
module mp2d_front #(
   parameter int MAX_POOL    = 8,
   parameter int ADDR_W      = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mp2d_pkg::size_cfg_type        cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic                          q_ready,
   output logic                          push,
   output logic signed [SAMPLE_BITS-1:0] push_sample,
   output logic [ADDR_W-1:0]             push_grp,
   output mp2d_pkg::win_flags_type       push_flags
);

   localparam int PCW  = $clog2(MAX_POOL);
   localparam int CMPW = mp2d_pkg::POOL_SIZE_W + 1;
   localparam int SW   = mp2d_pkg::SIZE_W;
   localparam int POSW = mp2d_pkg::SIZE_W - 1;

   logic [POSW-1:0]   col_pos_ff, col_pos_in, row_pos_ff, row_pos_in;
   logic [POSW-1:0]   chan_pos_ff, chan_pos_in;
   logic [POSW-1:0]   col_base_ff, col_base_in, row_base_ff, row_base_in;
   logic [PCW-1:0]    cw_ff, cw_in, rw_ff, rw_in;
   logic [ADDR_W-1:0] grp_ff, grp_in;

   logic [SW-1:0]   rem_r, rem_c, col_pos_next, row_pos_next, chan_next;
   logic [CMPW-1:0] cw_next, rw_next;
   logic            row_ok, col_ok, row_last, col_last, in_win;
   logic            col_end, row_end, line_end, frame_end, block_end, accept;

   always_comb begin
      // rows and columns left from the current window's start
      rem_r        = cfg.rows - SW'(row_base_ff);
      rem_c        = cfg.cols - SW'(col_base_ff);
      row_ok       = rem_r >= SW'(cfg.ph);
      col_ok       = rem_c >= SW'(cfg.pw);
      row_last     = rem_r < SW'({cfg.ph, 1'b0});
      col_last     = rem_c < SW'({cfg.pw, 1'b0});
      in_win       = row_ok && col_ok;
      cw_next      = CMPW'(cw_ff) + CMPW'(1);
      rw_next      = CMPW'(rw_ff) + CMPW'(1);
      col_end      = cw_next >= CMPW'(cfg.pw);
      row_end      = rw_next >= CMPW'(cfg.ph);
      col_pos_next = SW'(col_pos_ff) + SW'(1);
      row_pos_next = SW'(row_pos_ff) + SW'(1);
      chan_next    = SW'(chan_pos_ff) + SW'(1);
      line_end     = col_pos_next >= cfg.cols;
      frame_end    = row_pos_next >= cfg.rows;
      block_end    = chan_next >= cfg.chans;

      in_ready    = q_ready;
      accept      = in_valid && q_ready;
      push        = accept && in_win;
      push_sample = in_sample;
      push_grp    = grp_ff;
      push_flags.first_col = cw_ff == '0;
      push_flags.col_end   = col_end;
      push_flags.row_first = rw_ff == '0;
      push_flags.row_end   = row_end;
      push_flags.ch_done   = row_last && col_last;
      push_flags.blk_done  = row_last && col_last && block_end;

      col_pos_in  = col_pos_ff;
      row_pos_in  = row_pos_ff;
      chan_pos_in = chan_pos_ff;
      col_base_in = col_base_ff;
      row_base_in = row_base_ff;
      cw_in       = cw_ff;
      rw_in       = rw_ff;
      grp_in      = grp_ff;

      if (accept) begin
         if (in_win) begin
            if (col_end) begin
               cw_in       = '0;
               col_base_in = col_base_ff + POSW'(cfg.pw);
               grp_in      = grp_ff + ADDR_W'(1);
            end else begin
               cw_in = PCW'(cw_next);
            end
         end
         if (line_end) begin
            col_pos_in  = '0;
            col_base_in = '0;
            cw_in       = '0;
            grp_in      = '0;
            if (row_end) begin
               rw_in       = '0;
               row_base_in = row_base_ff + POSW'(cfg.ph);
            end else begin
               rw_in = PCW'(rw_next);
            end
            if (frame_end) begin
               row_pos_in  = '0;
               row_base_in = '0;
               rw_in       = '0;
               chan_pos_in = block_end ? '0 : POSW'(chan_next);
            end else begin
               row_pos_in = POSW'(row_pos_next);
            end
         end else begin
            col_pos_in = POSW'(col_pos_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         chan_pos_ff <= '0;
         col_base_ff <= '0;
         row_base_ff <= '0;
         cw_ff       <= '0;
         rw_ff       <= '0;
         grp_ff      <= '0;
      end else begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         chan_pos_ff <= chan_pos_in;
         col_base_ff <= col_base_in;
         row_base_ff <= row_base_in;
         cw_ff       <= cw_in;
         rw_ff       <= rw_in;
         grp_ff      <= grp_in;
      end
   end

endmodule

// ===== hw/rtl/mp2d_queue.sv =====
module mp2d_queue #(
   parameter int ADDR_W      = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          push_ready,
   input  logic signed [SAMPLE_BITS-1:0] push_sample,
   input  logic [ADDR_W-1:0]             push_grp,
   input  mp2d_pkg::win_flags_type       push_flags,
   input  logic                          pop,
   output logic                          head_valid,
   output logic signed [SAMPLE_BITS-1:0] head_sample,
   output logic [ADDR_W-1:0]             head_grp,
   output mp2d_pkg::win_flags_type       head_flags
);

   localparam int DEPTH = mp2d_pkg::QUEUE_DEPTH;
   localparam int PTRW  = mp2d_pkg::QUEUE_PTR_W;

   logic signed [SAMPLE_BITS-1:0] sample_q [DEPTH];
   logic [ADDR_W-1:0]             grp_q    [DEPTH];
   mp2d_pkg::win_flags_type       flags_q  [DEPTH];

   logic [PTRW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTRW:0]   count_ff, count_in;
   logic            do_push, do_pop;

   always_comb begin
      push_ready  = count_ff != (PTRW + 1)'(DEPTH);
      head_valid  = count_ff != '0;
      head_sample = sample_q[rd_ptr_ff];
      head_grp    = grp_q[rd_ptr_ff];
      head_flags  = flags_q[rd_ptr_ff];
      do_push     = push && push_ready;
      do_pop      = pop && head_valid;
      wr_ptr_in   = do_push ? wr_ptr_ff + PTRW'(1) : wr_ptr_ff;
      rd_ptr_in   = do_pop ? rd_ptr_ff + PTRW'(1) : rd_ptr_ff;
      count_in    = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTRW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTRW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         sample_q[wr_ptr_ff] <= push_sample;
         grp_q[wr_ptr_ff]    <= push_grp;
         flags_q[wr_ptr_ff]  <= push_flags;
      end
   end

endmodule

// ===== hw/rtl/mp2d_back.sv =====
module mp2d_back #(
   parameter int LINE_STORE_DEPTH = 1024,
   parameter int ADDR_W           = 10,
   parameter int SAMPLE_BITS      = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [SAMPLE_BITS-1:0] floor_value,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  logic signed [SAMPLE_BITS-1:0] q_sample,
   input  logic [ADDR_W-1:0]             q_grp,
   input  mp2d_pkg::win_flags_type       q_flags,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_BITS-1:0] out_pooled,
   output logic                          out_ch_done,
   output logic                          out_blk_done
);

   logic signed [SAMPLE_BITS-1:0] line_mem [LINE_STORE_DEPTH];

   logic signed [SAMPLE_BITS-1:0] run_max_ff, s1_m_ff, rd_data_ff, fwd_ff, pooled_ff;
   logic [ADDR_W-1:0]             s1_grp_ff;
   mp2d_pkg::win_flags_type       s1_flags_ff;
   logic                          s1_valid_ff, out_valid_ff, hit_ff;
   logic                          ch_done_ff, blk_done_ff;

   logic signed [SAMPLE_BITS-1:0] start, m_head, prev, v;
   logic                          en, s1_wr, s1_out;

   always_comb begin
      en     = !out_valid_ff || out_ready;
      q_pop  = en && q_valid;
      start  = q_flags.first_col ? floor_value : run_max_ff;
      m_head = (q_sample > start) ? q_sample : start;
      // a write to the same group on the edge of the read is taken from the bypass
      prev   = s1_flags_ff.row_first ? floor_value : (hit_ff ? fwd_ff : rd_data_ff);
      v      = (s1_m_ff > prev) ? s1_m_ff : prev;
      s1_wr  = s1_valid_ff && s1_flags_ff.col_end && !s1_flags_ff.row_end;
      s1_out = s1_valid_ff && s1_flags_ff.col_end && s1_flags_ff.row_end;

      out_valid    = out_valid_ff;
      out_pooled   = pooled_ff;
      out_ch_done  = ch_done_ff;
      out_blk_done = blk_done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= q_valid;
         out_valid_ff <= s1_out;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         run_max_ff  <= m_head;
         s1_m_ff     <= m_head;
         s1_grp_ff   <= q_grp;
         s1_flags_ff <= q_flags;
         hit_ff      <= s1_wr && (s1_grp_ff == q_grp);
         fwd_ff      <= v;
      end
      if (en && s1_out) begin
         pooled_ff   <= v;
         ch_done_ff  <= s1_flags_ff.ch_done;
         blk_done_ff <= s1_flags_ff.blk_done;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff <= line_mem[q_grp];
      end
      if (en && s1_wr) begin
         line_mem[s1_grp_ff] <= v;
      end
   end

endmodule

// ===== hw/rtl/max_pool_2d_stream.sv =====
// Non-overlapping 2-D max pooling over a streamed feature block, one signed sample per
// request, channel after channel, raster order within a channel. Sustains one request
// per clock unless the output stalls, and rows or columns that do not fill a whole
// window are consumed without a result. The rate is set by the line store of per-group
// partial maxima, one read and one write port, read one stage ahead with a bypass for a
// group written on the same edge. The line store needs no clearing pass after reset.
// The user writes sizes over the csr channel only between requests; the block does not
// enforce it. Zero sizes act as one and oversize ones saturate.
module max_pool_2d_stream #(
   parameter int LINE_STORE_DEPTH = 1024,
   parameter int SAMPLE_BITS      = 16,
   parameter int MAX_POOL         = 8
) (
   input  logic       clock,
   input  logic       reset,
   mp2d_req_if.sink   req_if,
   mp2d_rsp_if.source rsp_if,
   mp2d_csr_if.sink   csr_if
);

   localparam int ADDR_W  = (LINE_STORE_DEPTH > 1) ? $clog2(LINE_STORE_DEPTH) : 1;
   localparam int SW      = mp2d_pkg::SIZE_W;
   localparam int PSW     = mp2d_pkg::POOL_SIZE_W;
   localparam int FW      = mp2d_pkg::FLOOR_W;
   localparam int COL_CAP = (LINE_STORE_DEPTH < mp2d_pkg::SIZE_CAP) ?
                            LINE_STORE_DEPTH : mp2d_pkg::SIZE_CAP;

   logic [SW-1:0]                   frame_rows_ff, frame_cols_ff, channel_count_ff;
   logic [mp2d_pkg::POOL_RAW_W-1:0] pool_h_ff, pool_w_ff;
   logic [FW-1:0]                   floor_ff;

   mp2d_pkg::size_cfg_type        cfg;
   logic [SAMPLE_BITS+FW-1:0]     floor_ext;
   logic signed [SAMPLE_BITS-1:0] floor_value;

   logic                          q_ready, push, q_valid, q_pop;
   logic signed [SAMPLE_BITS-1:0] push_sample, head_sample;
   logic [ADDR_W-1:0]             push_grp, head_grp;
   mp2d_pkg::win_flags_type       push_flags, head_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff    <= mp2d_pkg::FRAME_ROWS_RESET;
         frame_cols_ff    <= mp2d_pkg::FRAME_COLS_RESET;
         channel_count_ff <= mp2d_pkg::CHANNEL_COUNT_RESET;
         pool_h_ff        <= mp2d_pkg::POOL_H_RESET;
         pool_w_ff        <= mp2d_pkg::POOL_W_RESET;
         floor_ff         <= mp2d_pkg::FLOOR_VALUE_RESET;
      end else if (csr_if.valid) begin
         case (mp2d_pkg::csr_index_type'(csr_if.index))
            mp2d_pkg::CSR_FRAME_ROWS:    frame_rows_ff    <= csr_if.data[SW-1:0];
            mp2d_pkg::CSR_FRAME_COLS:    frame_cols_ff    <= csr_if.data[SW-1:0];
            mp2d_pkg::CSR_CHANNEL_COUNT: channel_count_ff <= csr_if.data[SW-1:0];
            mp2d_pkg::CSR_POOL_H:        pool_h_ff <= csr_if.data[mp2d_pkg::POOL_RAW_W-1:0];
            mp2d_pkg::CSR_POOL_W:        pool_w_ff <= csr_if.data[mp2d_pkg::POOL_RAW_W-1:0];
            mp2d_pkg::CSR_FLOOR_VALUE:   floor_ff  <= csr_if.data[FW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_if.ready = 1'b1;

      if (frame_rows_ff == '0) cfg.rows = SW'(1);
      else if (frame_rows_ff > SW'(mp2d_pkg::SIZE_CAP)) cfg.rows = SW'(mp2d_pkg::SIZE_CAP);
      else cfg.rows = frame_rows_ff;

      if (frame_cols_ff == '0) cfg.cols = SW'(1);
      else if (frame_cols_ff > SW'(COL_CAP)) cfg.cols = SW'(COL_CAP);
      else cfg.cols = frame_cols_ff;

      if (channel_count_ff == '0) cfg.chans = SW'(1);
      else if (channel_count_ff > SW'(mp2d_pkg::SIZE_CAP)) cfg.chans = SW'(mp2d_pkg::SIZE_CAP);
      else cfg.chans = channel_count_ff;

      if (pool_h_ff == '0) cfg.ph = PSW'(1);
      else if (PSW'(pool_h_ff) > PSW'(MAX_POOL)) cfg.ph = PSW'(MAX_POOL);
      else cfg.ph = PSW'(pool_h_ff);

      if (pool_w_ff == '0) cfg.pw = PSW'(1);
      else if (PSW'(pool_w_ff) > PSW'(MAX_POOL)) cfg.pw = PSW'(MAX_POOL);
      else cfg.pw = PSW'(pool_w_ff);

      // floor register is zero-extended, then read at the sample width
      floor_ext   = {{SAMPLE_BITS{1'b0}}, floor_ff};
      floor_value = floor_ext[SAMPLE_BITS-1:0];
   end

   mp2d_front #(
      .MAX_POOL    (MAX_POOL),
      .ADDR_W      (ADDR_W),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .in_sample   (req_if.sample),
      .q_ready     (q_ready),
      .push        (push),
      .push_sample (push_sample),
      .push_grp    (push_grp),
      .push_flags  (push_flags)
   );

   mp2d_queue #(
      .ADDR_W      (ADDR_W),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_ready  (q_ready),
      .push_sample (push_sample),
      .push_grp    (push_grp),
      .push_flags  (push_flags),
      .pop         (q_pop),
      .head_valid  (q_valid),
      .head_sample (head_sample),
      .head_grp    (head_grp),
      .head_flags  (head_flags)
   );

   mp2d_back #(
      .LINE_STORE_DEPTH (LINE_STORE_DEPTH),
      .ADDR_W           (ADDR_W),
      .SAMPLE_BITS      (SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .floor_value  (floor_value),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_sample     (head_sample),
      .q_grp        (head_grp),
      .q_flags      (head_flags),
      .out_valid    (rsp_if.valid),
      .out_ready    (rsp_if.ready),
      .out_pooled   (rsp_if.pooled),
      .out_ch_done  (rsp_if.channel_done),
      .out_blk_done (rsp_if.block_done)
   );

`ifndef ASSERT_OFF
   a_blk_has_ch: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.block_done |-> rsp_if.channel_done)
      else $error("block end without channel end");

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(q_pop, 2))
      else $error("result without a request popped two cycles before");

   a_clean_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result right after reset");
`endif

endmodule
